@@ hdl/dtim_pkg.sv @@
// Package for the digest-to-id table: operation codes, key and id types,
// the link record passed between neighboring slots, and the result record.
// No dependencies.
`default_nettype none
package dtim_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int ID_W        = 16;
	localparam int CNT_OUT_W   = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] mid;
		logic [31:0] lo;
	} key_t;

	// Running search state handed from one slot to the next.
	typedef struct packed {
		logic            tok;
		logic            found;
		logic [ID_W-1:0] fid;
		logic            claimed;
	} link_t;

	typedef struct packed {
		logic                 found;
		logic [ID_W-1:0]      fid;
		logic                 full;
		logic [CNT_OUT_W-1:0] cnt;
	} res_t;

endpackage
`default_nettype wire

@@ hdl/dtim_if.sv @@
// Handshake channels of the digest-to-id table: request and response.
// Depends on nothing; field widths are fixed by the transaction format.
`default_nettype none
interface dtim_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [63:0] key_high;
	logic [63:0] key_middle;
	logic [31:0] key_low;
	logic [15:0] entry_id;

	modport source (output valid, opcode, key_high, key_middle, key_low, entry_id,
		input ready);
	modport sink (input valid, opcode, key_high, key_middle, key_low, entry_id,
		output ready);
endinterface

interface dtim_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] found_id;
	logic        table_full;
	logic [6:0]  entry_count;

	modport source (output valid, found, found_id, table_full, entry_count,
		input ready);
	modport sink (input valid, found, found_id, table_full, entry_count,
		output ready);
endinterface
`default_nettype wire

@@ hdl/dtim_slot.sv @@
// One slot of the table: holds a digest, its id and a valid bit, and
// updates the search record as the token passes. Depends on dtim_pkg.
`default_nettype none
module dtim_slot import dtim_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire link_t           link_in,
	input  wire op_t             op,
	input  wire key_t            key,
	input  wire logic [ID_W-1:0] id,
	output link_t                link_out
);

	logic            vld_q;
	key_t            key_q;
	logic [ID_W-1:0] id_q;
	link_t           link_q;
	logic            hit;
	logic            claim;
	logic            wipe;

	// Valid slots always form a prefix, so the first free slot reached
	// without a hit is the lowest free one and no later slot can match.
	always_comb begin
		hit   = link_in.tok && vld_q && (key_q == key) && !link_in.found &&
			(op == OP_INSERT || op == OP_LOOKUP);
		claim = link_in.tok && (op == OP_INSERT) && !vld_q &&
			!link_in.found && !link_in.claimed;
		wipe  = link_in.tok && (op == OP_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			link_q <= '0;
		end else begin
			if (wipe)
				vld_q <= 1'b0;
			else if (claim)
				vld_q <= 1'b1;
			link_q.tok     <= link_in.tok;
			link_q.found   <= link_in.found | hit;
			link_q.fid     <= hit ? id_q : link_in.fid;
			link_q.claimed <= link_in.claimed | claim;
		end
	end

	always_ff @(posedge clk) begin
		if (claim)
			key_q <= key;
		if (claim || (hit && op == OP_INSERT))
			id_q <= id;
	end

	assign link_out = link_q;

endmodule
`default_nettype wire

@@ hdl/digest_to_id_map.sv @@
// Digest-to-id associative table: a row of ENTRIES slots searched by a token.
// An accepted request is registered, its token then walks the slot row one slot
// per cycle, and the result is registered at the output; the next request waits
// until the token leaves the row and no stalled result is parked in the hold stage.
// Reset clears all valid bits, the entry count and the response valid at once.
// Depends on dtim_pkg, dtim_if and dtim_slot.
`default_nettype none
module digest_to_id_map import dtim_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dtim_req_if.sink    cmd,
	dtim_rsp_if.source  rsp
);

	localparam int CW = $clog2(ENTRIES + 1);

	op_t             op_q;
	key_t            key_q;
	logic [ID_W-1:0] id_q;
	logic            start_q;
	logic            busy_q;
	logic [CW-1:0]   count_q;
	logic            out_vld_q;
	res_t            out_q;
	logic            hold_vld_q;
	res_t            hold_q;

	link_t           head;
	link_t           links [ENTRIES];
	link_t           tail;
	logic            accept;
	logic            out_free;
	logic [CW-1:0]   cnt_nxt;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;
	res_t            res;

	assign cmd.ready = !busy_q && !hold_vld_q;
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_vld_q || rsp.ready;

	always_comb begin
		head     = '0;
		head.tok = start_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_row
		if (i == 0) begin : g_first
			dtim_slot u_slot (
				.clk(clk), .arst_n(arst_n), .link_in(head),
				.op(op_q), .key(key_q), .id(id_q), .link_out(links[i])
			);
		end else begin : g_rest
			dtim_slot u_slot (
				.clk(clk), .arst_n(arst_n), .link_in(links[i-1]),
				.op(op_q), .key(key_q), .id(id_q), .link_out(links[i])
			);
		end
	end

	assign tail = links[ENTRIES-1];

	always_comb begin
		if (op_q == OP_CLEAR)
			cnt_nxt = '0;
		else
			cnt_nxt = count_q + CW'(tail.claimed);
		cnt_ext   = {{CNT_OUT_W{1'b0}}, cnt_nxt};
		res.found = tail.found;
		res.fid   = tail.fid;
		res.full  = (op_q == OP_INSERT) && !tail.found && !tail.claimed;
		res.cnt   = cnt_ext[CNT_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= 1'b0;
			busy_q     <= 1'b0;
			count_q    <= '0;
			out_vld_q  <= 1'b0;
			hold_vld_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept)
				busy_q <= 1'b1;
			else if (tail.tok)
				busy_q <= 1'b0;
			if (tail.tok)
				count_q <= cnt_nxt;
			// Park the result in the hold stage when the output is stalled.
			if (tail.tok) begin
				if (out_free)
					out_vld_q <= 1'b1;
				else
					hold_vld_q <= 1'b1;
			end else if (hold_vld_q && out_free) begin
				out_vld_q  <= 1'b1;
				hold_vld_q <= 1'b0;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(cmd.opcode);
			key_q  <= '{hi: cmd.key_high, mid: cmd.key_middle, lo: cmd.key_low};
			id_q   <= cmd.entry_id;
		end
		if (tail.tok) begin
			if (out_free)
				out_q <= res;
			else
				hold_q <= res;
		end else if (hold_vld_q && out_free) begin
			out_q <= hold_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.found       = out_q.found;
	assign rsp.found_id    = out_q.fid;
	assign rsp.table_full  = out_q.full;
	assign rsp.entry_count = out_q.cnt;

endmodule
`default_nettype wire

@@ hdl/dtim_chk.sv @@
// Port-level checks for the digest-to-id table, bound to the top level.
// Depends on digest_to_id_map and its channel interfaces.
`default_nettype none
module dtim_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        found,
	input wire logic [15:0] found_id,
	input wire logic        table_full,
	input wire logic [6:0]  entry_count
);

	// A transaction walks the whole row, so two requests never land back to back.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !(in_valid && in_ready))
		else $error("requests accepted on consecutive cycles");

	a_miss_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (found_id == 16'd0))
		else $error("nonzero id without a match");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> !found)
		else $error("refused insert reports a match");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(found) &&
			$stable(found_id) && $stable(table_full) && $stable(entry_count)))
		else $error("stalled response changed");

endmodule

bind digest_to_id_map dtim_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(cmd.valid),
	.in_ready(cmd.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.found(rsp.found),
	.found_id(rsp.found_id),
	.table_full(rsp.table_full),
	.entry_count(rsp.entry_count)
);
`default_nettype wire
